// File: hdl/bmms_pkg.sv
// shared types and constants for the block min/max summary
`timescale 1ns / 1ps

package bmms_pkg;

  localparam int CHANNELS = 48;

  localparam int CH_W    = 6;
  localparam int VALUE_W = 32;
  localparam int TIME_W  = 40;
  localparam int COUNT_W = 16;
  localparam int INDEX_W = 32;

  localparam int S_DATA_W = 80;
  localparam int M_DATA_W = 264;
  localparam int M_USER_W = 2;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [ADDR_W-1:0] REG_BLOCK_LENGTH = 3'd0;
  localparam logic [COUNT_W-1:0] BLOCK_LENGTH_RST = 16'd1024;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } emit_state_t;

  // per-channel accumulator state held by one cell
  typedef struct packed {
    logic                      seen;
    logic                      gap;
    logic signed [VALUE_W-1:0] min_value;
    logic [TIME_W-1:0]         min_time;
    logic signed [VALUE_W-1:0] max_value;
    logic [TIME_W-1:0]         max_time;
  } chan_state_t;

  // sample broadcast to every cell
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [TIME_W-1:0]         time_us;
    logic                      available;
  } sample_t;

endpackage

// File: hdl/block_min_max_summary.sv
// top level of the block min/max summary: stream control, block counters, apb register
`timescale 1ns / 1ps

// Samples come in on the s_ stream, one channel per request; s_tlast closes a
// record and s_tuser says whether the sample is valid. Each channel has a cell
// that keeps min, max, their first times and seen/gap flags; the cells update
// in the cycle the request is taken, so one sample is accepted per cycle
// while no readout holds the input off. When the record count reaches or
// passes block_length (0 acts as 1) the block closes: from the next cycle the
// cells shift toward the head one place per accepted output request, giving
// CHANNELS summaries on m_ in channel order, m_tlast on the last one. Empty
// state enters the row from the tail, so the row is clear when readout ends.
// The input is held off for the readout; a stalled receiver simply freezes
// the row. Input resumes the cycle after the last summary is taken.
// Reset clears all flags, counters and the record index and sets block_length
// to 1024; no clearing pass is needed. block_length is written over apb at
// byte address 0; only paddr[2] is decoded, so addresses 0 to 3 reach it.

module block_min_max_summary
  import bmms_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // stream in
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,  // channel[5:0], time_us[45:6], value[77:46], zero pad
  input  logic                s_tuser,  // available
  input  logic                s_tlast,
  // stream out
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,  // out_channel, min_value, min_time, max_value,
                                        // max_time, first_sample, start_time, end_time, pad
  output logic [M_USER_W-1:0] m_tuser,  // seen, gap
  output logic                m_tlast,
  // apb configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  emit_state_t state, state_next;

  logic [COUNT_W-1:0] block_length;
  logic [COUNT_W-1:0] block_count;
  logic [INDEX_W-1:0] block_first_index;
  logic [TIME_W-1:0]  block_start_time;
  logic [TIME_W-1:0]  block_end_time;
  logic [INDEX_W-1:0] record_index;
  logic               block_open;
  logic [CH_W-1:0]    emit_ch;

  logic [CH_W-1:0]    in_channel;
  sample_t            sample;
  logic               in_acc;
  logic               out_acc;
  logic [COUNT_W-1:0] count_inc;
  logic [COUNT_W-1:0] eff_length;
  logic               close;
  logic               last_ch;
  logic               cfg_wr;
  chan_state_t        head;

  assign in_channel        = s_tdata[5:0];
  assign sample.time_us    = s_tdata[45:6];
  assign sample.value      = s_tdata[77:46];
  assign sample.available  = s_tuser;

  assign in_acc     = s_tvalid && s_tready;
  assign out_acc    = m_tvalid && m_tready;
  assign count_inc  = block_count + 16'd1;
  assign eff_length = (block_length == '0) ? 16'd1 : block_length;
  assign close      = in_acc && s_tlast && (count_inc >= eff_length);
  assign last_ch    = (emit_ch == CH_W'(CHANNELS - 1));

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_length <= BLOCK_LENGTH_RST;
    end else if (cfg_wr && paddr[2] == REG_BLOCK_LENGTH[2]) begin
      block_length <= pwdata[COUNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_BLOCK_LENGTH[2]) begin
      prdata = {{(DATA_W-COUNT_W){1'b0}}, block_length};
    end
  end

  // readout sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (close) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_acc && last_ch) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    unique case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_EMIT: m_tvalid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      emit_ch <= '0;
    end else begin
      state <= state_next;
      if (out_acc) begin
        emit_ch <= last_ch ? '0 : emit_ch + CH_W'(1);
      end
    end
  end

  // block bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      block_count       <= '0;
      block_first_index <= '0;
      block_start_time  <= '0;
      block_end_time    <= '0;
      record_index      <= '0;
      block_open        <= 1'b0;
    end else if (in_acc) begin
      block_end_time <= sample.time_us;
      if (!block_open) begin
        block_first_index <= record_index;
        block_start_time  <= sample.time_us;
      end
      if (close) begin
        block_count <= '0;
        block_open  <= 1'b0;
      end else begin
        block_open <= 1'b1;
        if (s_tlast) begin
          block_count <= count_inc;
        end
      end
      if (s_tlast) begin
        record_index <= record_index + 32'd1;
      end
    end
  end

  bmms_chain u_chain (
    .clk     (clk),
    .rst     (rst),
    .upd_en  (in_acc),
    .channel (in_channel),
    .sample  (sample),
    .shift   (out_acc),
    .head    (head)
  );

  // unseen channel reads back zero min/max
  always_comb begin
    m_tdata          = '0;
    m_tdata[5:0]     = emit_ch;
    m_tdata[37:6]    = head.seen ? head.min_value : '0;
    m_tdata[77:38]   = head.seen ? head.min_time  : '0;
    m_tdata[109:78]  = head.seen ? head.max_value : '0;
    m_tdata[149:110] = head.seen ? head.max_time  : '0;
    m_tdata[181:150] = block_first_index;
    m_tdata[221:182] = block_start_time;
    m_tdata[261:222] = block_end_time;
  end

  assign m_tuser = {head.gap, head.seen};
  assign m_tlast = last_ch;

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input and readout active together");

  a_close_starts_readout: assert property (@(posedge clk) disable iff (rst)
    close |=> (m_tvalid && emit_ch == '0))
    else $error("block close did not start readout at channel 0");

  a_last_ends_readout: assert property (@(posedge clk) disable iff (rst)
    (out_acc && m_tlast) |=> (s_tready && !m_tvalid))
    else $error("readout did not end after last summary");

  a_closed_count_zero: assert property (@(posedge clk) disable iff (rst)
    !block_open |-> (block_count == '0))
    else $error("record count nonzero while no block is open");

endmodule

// File: hdl/bmms_cell.sv
// one channel cell: folds samples into min/max and shifts toward the head on readout
`timescale 1ns / 1ps

module bmms_cell
  import bmms_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        hit,
  input  sample_t     sample,
  input  logic        shift,
  input  chan_state_t nbr_in,
  output chan_state_t state
);

  chan_state_t state_next;

  always_comb begin
    state_next = state;
    if (shift) begin
      state_next = nbr_in;
    end else if (hit) begin
      if (!sample.available) begin
        state_next.gap = 1'b1;
      end else if (!state.seen) begin
        state_next.seen      = 1'b1;
        state_next.min_value = sample.value;
        state_next.max_value = sample.value;
        state_next.min_time  = sample.time_us;
        state_next.max_time  = sample.time_us;
      end else begin
        // strict compares so a tie keeps the earlier time
        if (sample.value < state.min_value) begin
          state_next.min_value = sample.value;
          state_next.min_time  = sample.time_us;
        end
        if (sample.value > state.max_value) begin
          state_next.max_value = sample.value;
          state_next.max_time  = sample.time_us;
        end
      end
    end
  end

  // only the flags need a reset; min/max are read only when seen is set
  always_ff @(posedge clk) begin
    if (rst) begin
      state.seen <= 1'b0;
      state.gap  <= 1'b0;
    end else begin
      state.seen <= state_next.seen;
      state.gap  <= state_next.gap;
    end
    state.min_value <= state_next.min_value;
    state.min_time  <= state_next.min_time;
    state.max_value <= state_next.max_value;
    state.max_time  <= state_next.max_time;
  end

endmodule

// File: hdl/bmms_chain.sv
// row of channel cells; cell 0 is the readout head
`timescale 1ns / 1ps

module bmms_chain
  import bmms_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            upd_en,
  input  logic [CH_W-1:0] channel,
  input  sample_t         sample,
  input  logic            shift,
  output chan_state_t     head
);

  chan_state_t cs [CHANNELS];
  chan_state_t cleared;

  // empty state shifted in behind the readout
  assign cleared = '0;

  for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
    logic        hit;
    chan_state_t nbr;

    assign hit = upd_en && (channel == CH_W'(i));

    if (i == CHANNELS - 1) begin : g_tail
      assign nbr = cleared;
    end else begin : g_mid
      assign nbr = cs[i+1];
    end

    bmms_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .hit    (hit),
      .sample (sample),
      .shift  (shift),
      .nbr_in (nbr),
      .state  (cs[i])
    );
  end

  assign head = cs[0];

endmodule

// File: sim/tb_top.sv
// self-checking testbench for the block min/max summary
`timescale 1ns / 1ps

module tb_top
  import bmms_pkg::*;
();

  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int MAX_REPORTS    = 60;

  typedef struct {
    logic [CH_W-1:0]           ch;
    logic [TIME_W-1:0]         t;
    logic signed [VALUE_W-1:0] v;
    logic                      av;
    logic                      re;
  } sample_req_t;

  typedef struct {
    logic [CH_W-1:0]           ch;
    logic signed [VALUE_W-1:0] min_v;
    logic [TIME_W-1:0]         min_t;
    logic signed [VALUE_W-1:0] max_v;
    logic [TIME_W-1:0]         max_t;
    logic                      seen;
    logic                      gap;
    logic [INDEX_W-1:0]        first_idx;
    logic [TIME_W-1:0]         start_t;
    logic [TIME_W-1:0]         end_t;
    logic                      last;
  } summary_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;  // channel, time_us, value, zero pad
  logic                s_tuser = 1'b0;  // available
  logic                s_tlast = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;  // out_channel, min_value, min_time, max_value, max_time,
                                 // first_sample, start_time, end_time, pad
  logic [M_USER_W-1:0] m_tuser;  // seen, gap
  logic                m_tlast;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  block_min_max_summary uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the block state
  logic [COUNT_W-1:0]        blk_len;
  logic signed [VALUE_W-1:0] min_v [CHANNELS];
  logic signed [VALUE_W-1:0] max_v [CHANNELS];
  logic [TIME_W-1:0]         min_t [CHANNELS];
  logic [TIME_W-1:0]         max_t [CHANNELS];
  logic                      seen_f [CHANNELS];
  logic                      gap_f [CHANNELS];
  logic [COUNT_W-1:0]        rec_count;
  logic [INDEX_W-1:0]        blk_first;
  logic [TIME_W-1:0]         blk_start;
  logic [TIME_W-1:0]         blk_end;
  logic [INDEX_W-1:0]        rec_idx;
  logic                      blk_open;

  sample_req_t item_q[$];
  summary_t    summary_q[$];
  sample_req_t cur;
  summary_t    got_sum;
  summary_t    want_sum;
  logic [TIME_W-1:0] tstamp;

  bit steady;
  bit hold_armed;
  bit hold_used;
  int hold_left;
  int stall_cycles;
  int errors;
  int n_items, n_records, n_blocks, n_checked, n_gaps, n_stray;

  function automatic void reset_channel_stats();
    for (int c = 0; c < CHANNELS; c++) begin
      min_v[c]  = 32'sh7FFF_FFFF;
      max_v[c]  = 32'sh8000_0000;
      min_t[c]  = '0;
      max_t[c]  = '0;
      seen_f[c] = 1'b0;
      gap_f[c]  = 1'b0;
    end
  endfunction

  // fold one accepted sample into the shadow state, queue summaries on block close
  function automatic void accumulate_sample(sample_req_t s);
    summary_t r;
    int eff_len;
    n_items++;
    if (!blk_open) begin
      blk_open  = 1'b1;
      blk_first = rec_idx;
      blk_start = s.t;
    end
    blk_end = s.t;
    if (s.ch < CHANNELS) begin
      if (!s.av) begin
        gap_f[s.ch] = 1'b1;
        n_gaps++;
      end else if (!seen_f[s.ch]) begin
        seen_f[s.ch] = 1'b1;
        min_v[s.ch]  = s.v;
        max_v[s.ch]  = s.v;
        min_t[s.ch]  = s.t;
        max_t[s.ch]  = s.t;
      end else begin
        // strict compares: ties keep the earlier time
        if (s.v < min_v[s.ch]) begin
          min_v[s.ch] = s.v;
          min_t[s.ch] = s.t;
        end
        if (s.v > max_v[s.ch]) begin
          max_v[s.ch] = s.v;
          max_t[s.ch] = s.t;
        end
      end
    end else begin
      n_stray++;
    end
    if (s.re) begin
      n_records++;
      rec_idx   = rec_idx + 32'd1;
      rec_count = rec_count + 16'd1;
      eff_len   = (blk_len == 0) ? 1 : int'(blk_len);
      if (int'(rec_count) >= eff_len) begin
        for (int c = 0; c < CHANNELS; c++) begin
          r.ch        = c[CH_W-1:0];
          r.seen      = seen_f[c];
          r.min_v     = seen_f[c] ? min_v[c] : '0;
          r.min_t     = seen_f[c] ? min_t[c] : '0;
          r.max_v     = seen_f[c] ? max_v[c] : '0;
          r.max_t     = seen_f[c] ? max_t[c] : '0;
          r.gap       = gap_f[c];
          r.first_idx = blk_first;
          r.start_t   = blk_start;
          r.end_t     = blk_end;
          r.last      = (c == CHANNELS - 1);
          summary_q.insert(summary_q.size(), r);
        end
        reset_channel_stats();
        rec_count = '0;
        blk_open  = 1'b0;
        n_blocks++;
      end
    end
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t ch %0d %s mismatch: expected %h, actual %h",
                 $time, want_sum.ch, name, want, got);
    end
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        accumulate_sample(cur);
      if (!s_tvalid || s_tready) begin
        if (item_q.size() > 0 && (steady || $urandom_range(99) >= 26)) begin
          cur = item_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {2'b00, cur.v, cur.t, cur.ch};
          s_tuser  <= cur.av;
          s_tlast  <= cur.re;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_sum.ch        = m_tdata[5:0];
        got_sum.min_v     = m_tdata[37:6];
        got_sum.min_t     = m_tdata[77:38];
        got_sum.max_v     = m_tdata[109:78];
        got_sum.max_t     = m_tdata[149:110];
        got_sum.first_idx = m_tdata[181:150];
        got_sum.start_t   = m_tdata[221:182];
        got_sum.end_t     = m_tdata[261:222];
        got_sum.seen      = m_tuser[0];
        got_sum.gap       = m_tuser[1];
        got_sum.last      = m_tlast;
        if (summary_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t unexpected summary: expected none, actual ch %0d", $time, got_sum.ch);
        end else begin
          want_sum = summary_q.pop_front();
          n_checked++;
          check_field("out_channel", 64'(want_sum.ch), 64'(got_sum.ch));
          check_field("min_value", 64'(want_sum.min_v), 64'(got_sum.min_v));
          check_field("min_time", 64'(want_sum.min_t), 64'(got_sum.min_t));
          check_field("max_value", 64'(want_sum.max_v), 64'(got_sum.max_v));
          check_field("max_time", 64'(want_sum.max_t), 64'(got_sum.max_t));
          check_field("seen", 64'(want_sum.seen), 64'(got_sum.seen));
          check_field("gap", 64'(want_sum.gap), 64'(got_sum.gap));
          check_field("first_sample", 64'(want_sum.first_idx), 64'(got_sum.first_idx));
          check_field("start_time", 64'(want_sum.start_t), 64'(got_sum.start_t));
          check_field("end_time", 64'(want_sum.end_t), 64'(got_sum.end_t));
          check_field("last", 64'(want_sum.last), 64'(got_sum.last));
        end
      end
      // one long hold-off once readout starts in the pressure phase
      if (hold_armed && !hold_used && m_tvalid) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= steady || ($urandom_range(99) >= 26);
      end
    end
  end

  // watchdog: cycles with work pending but no request moving
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (item_q.size() == 0 && !s_tvalid && summary_q.size() == 0)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no progress, %0d summaries outstanding", $time, summary_q.size());
      $display("FAIL block_min_max_summary");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic apb_access(input bit wr, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (item_q.size() > 0 || s_tvalid || summary_q.size() > 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic verify_length(logic [COUNT_W-1:0] want);
    logic [DATA_W-1:0] rd;
    apb_access(1'b0, REG_BLOCK_LENGTH, '0, rd);
    if (rd !== DATA_W'(want)) begin
      errors++;
      $display("%0t block_length readback mismatch: expected %h, actual %h", $time, want, rd);
    end
  endtask

  task automatic set_block_length(logic [COUNT_W-1:0] len);
    logic [DATA_W-1:0] unused;
    wait_idle();
    apb_access(1'b1, REG_BLOCK_LENGTH, DATA_W'(len), unused);
    blk_len = len;
    verify_length(len);
    @(negedge clk);
  endtask

  task automatic add_sample(logic [CH_W-1:0] ch, logic [TIME_W-1:0] t,
                            logic [VALUE_W-1:0] v, logic av, logic re);
    sample_req_t s;
    s.ch = ch;
    s.t  = t;
    s.v  = v;
    s.av = av;
    s.re = re;
    item_q.insert(item_q.size(), s);
  endtask

  // mostly ascending-channel records with random content, some scrambled ones
  task automatic queue_records(int n);
    sample_req_t s;
    int left;
    int len;
    int ch;
    bit broken;
    left = n;
    while (left > 0) begin
      broken = ($urandom_range(99) < 12);
      len = $urandom_range(1, 10);
      if (len > left)
        len = left;
      if ($urandom_range(99) < 8)
        tstamp = TIME_W'({$urandom, $urandom});
      else
        tstamp = tstamp + $urandom_range(0, 3);
      ch = $urandom_range(0, 7);
      for (int i = 0; i < len; i++) begin
        if (broken)
          s.ch = CH_W'($urandom_range(0, 63));
        else if ($urandom_range(99) < 5)
          s.ch = CH_W'($urandom_range(CHANNELS, 63));
        else
          s.ch = CH_W'((ch < CHANNELS) ? ch : CHANNELS - 1);
        ch = ch + $urandom_range(1, 6);
        s.t  = tstamp;
        s.av = ($urandom_range(99) >= 15);
        case ($urandom_range(9))
          0:       s.v = 32'sh7FFF_FFFF;
          1:       s.v = 32'sh8000_0000;
          2:       s.v = '1;
          3:       s.v = 32'($urandom_range(0, 3)) << 16;
          default: s.v = $urandom;
        endcase
        s.re = broken ? ($urandom_range(99) < 30) : (i == len - 1);
        item_q.insert(item_q.size(), s);
      end
      left -= len;
    end
  endtask

  initial begin
    blk_len   = BLOCK_LENGTH_RST;
    rec_count = '0;
    blk_first = '0;
    blk_start = '0;
    blk_end   = '0;
    rec_idx   = '0;
    blk_open  = 1'b0;
    tstamp    = '0;
    reset_channel_stats();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    verify_length(BLOCK_LENGTH_RST);
    @(negedge clk);

    // two records under the reset length: extremes, stray channel, gap, ties
    add_sample(6'd0, '0, 32'h7FFF_FFFF, 1'b1, 1'b0);
    add_sample(6'd1, '0, 32'h8000_0000, 1'b1, 1'b0);
    add_sample(6'd63, '0, 32'd5, 1'b1, 1'b0);
    add_sample(6'd2, '0, 32'd0, 1'b0, 1'b0);
    add_sample(6'd3, '0, 32'd100, 1'b1, 1'b1);
    add_sample(6'd0, TIME_MAX, 32'h7FFF_FFFF, 1'b1, 1'b0);
    add_sample(6'd1, TIME_MAX, 32'h8000_0000, 1'b1, 1'b0);
    add_sample(6'd3, TIME_MAX, 32'hFFFF_FFFF, 1'b1, 1'b0);
    add_sample(6'd47, TIME_MAX, 32'd0, 1'b1, 1'b1);
    // length dropped below the count: closes on the next record end
    set_block_length(16'd1);
    add_sample(6'd5, 40'h12_3456_789A, 32'h1234_5678, 1'b1, 1'b1);
    // zero acts as one
    set_block_length(16'd0);
    add_sample(6'd10, 40'd7, 32'hFFFF_FFFB, 1'b1, 1'b0);
    add_sample(6'd60, 40'd8, 32'd9, 1'b1, 1'b1);
    add_sample(6'd47, 40'd9, 32'd0, 1'b0, 1'b1);
    set_block_length(16'hFFFF);
    add_sample(6'd4, 40'd100, 32'd1, 1'b1, 1'b1);
    add_sample(6'd4, 40'd101, 32'd2, 1'b1, 1'b1);
    add_sample(6'd4, 40'd102, 32'd2, 1'b1, 1'b1);
    set_block_length(16'd2);
    add_sample(6'd4, 40'd103, 32'hFFFF_FFFE, 1'b1, 1'b1);

    set_block_length(16'd3);
    queue_records(55);
    // no idling on either side
    wait_idle();
    steady = 1'b1;
    set_block_length(16'($urandom_range(1, 5)));
    queue_records(55);
    wait_idle();
    steady = 1'b0;
    // receiver holds off while the sender keeps offering samples
    hold_armed = 1'b1;
    set_block_length(16'd2);
    queue_records(55);
    set_block_length(16'd4);
    queue_records(55);

    wait_idle();
    repeat (10) @(posedge clk);
    $display("covered %0d samples in %0d records (%0d gaps, %0d stray channels), %0d block closes",
             n_items, n_records, n_gaps, n_stray, n_blocks);
    $display("checked %0d channel summaries over lengths 0 to 5, 65535 and a lowered length",
             n_checked);
    $display("%0d errors", errors);
    if (errors == 0)
      $display("PASS block_min_max_summary");
    else
      $display("FAIL block_min_max_summary");
    $finish;
  end

endmodule

// File: filelist.f
hdl/bmms_pkg.sv
hdl/bmms_cell.sv
hdl/bmms_chain.sv
hdl/block_min_max_summary.sv
sim/tb_top.sv
